// File: design/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types, constants and helpers for the integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package itda_pkg;

   // default input width
   localparam int INPUT_BITS_DEFAULT = 32;

   // ASCII codes
   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   // decimal digits needed for a magnitude of up to 2**(bits-1)
   // (1233/4096 approximates log10(2), exact over 8..64 bits)
   function automatic int digits_for(input int bits);
      return (((bits - 1) * 1233) >> 12) + 1;
   endfunction

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // controls from the sequencer to the shift/add-3 unit
   typedef struct packed {
      logic load;
      logic shift;
   } dabble_ctrl_type;

endpackage

// File: design/itda_dabble.sv
// ----------------------------------------------------------------------------
// itda_dabble
// Shift and add-3 binary to BCD converter: one magnitude bit per shift step.
// ----------------------------------------------------------------------------
module itda_dabble
   import itda_pkg::*;
#(
   parameter int INPUT_BITS = INPUT_BITS_DEFAULT,
   parameter int NDIG       = digits_for(INPUT_BITS)
) (
   input  logic                  clock,
   input  dabble_ctrl_type       ctrl,
   input  logic [INPUT_BITS-1:0] load_mag,
   output logic [4*NDIG-1:0]     bcd
);

   logic [INPUT_BITS-1:0] bin_ff, bin_in;
   logic [4*NDIG-1:0]     bcd_ff, bcd_in;
   logic [4*NDIG-1:0]     bcd_adj;

   // add 3 to every digit of 5 or more, ahead of the shift
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // load or shift the combined BCD/binary register
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = load_mag;
         bcd_in = '0;
      end else if (ctrl.shift) begin
         bin_in = {bin_ff[INPUT_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[4*NDIG-2:0], bin_ff[INPUT_BITS-1]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd = bcd_ff;

endmodule

// File: design/int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, most significant character first.
// ----------------------------------------------------------------------------
//  channel   ports                               direction
//  request   req_valid req_ready req_value       in  (signed INPUT_BITS)
//  response  rsp_valid rsp_ready rsp_character   out (8-bit ASCII, rsp_last)
//
//  One request is accepted while idle, converted by INPUT_BITS shift/add-3
//  steps in the converter, then the leading digit is located and the text
//  is sent at one character per cycle while the response is not stalled.
//  req_ready is high only while the sequencer is idle; the next request may
//  be taken while the final character still waits in the output register.
//  A stalled response holds the sequencer. Reset clears the control state.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
   import itda_pkg::*;
#(
   parameter int INPUT_BITS = INPUT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [INPUT_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);

   localparam int NDIG = digits_for(INPUT_BITS);
   localparam int DW   = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int CW   = (INPUT_BITS > 1) ? $clog2(INPUT_BITS) : 1;

   state_type        state_ff, state_in;
   logic [CW-1:0]    bitcnt_ff, bitcnt_in;
   logic [DW-1:0]    dptr_ff, dptr_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_character_ff, rsp_character_in;
   logic             rsp_last_ff, rsp_last_in;

   dabble_ctrl_type       ctrl;
   logic [INPUT_BITS-1:0] mag;
   logic [4*NDIG-1:0]     bcd;
   logic [DW-1:0]         top;
   logic [3:0]            digit;
   logic                  out_free;
   logic                  out_load;

   // two's complement magnitude; the most negative value maps onto itself
   assign mag = req_value[INPUT_BITS-1] ? (~req_value + 1'b1) : req_value;

   itda_dabble #(
      .INPUT_BITS (INPUT_BITS),
      .NDIG       (NDIG)
   ) u_dabble (
      .clock    (clock),
      .ctrl     (ctrl),
      .load_mag (mag),
      .bcd      (bcd)
   );

   // highest nonzero digit, zero when the value is zero
   always_comb begin
      top = '0;
      for (int i = 1; i < NDIG; i++) begin
         if (bcd[4*i +: 4] != 4'd0) begin
            top = DW'(i);
         end
      end
   end

   assign digit    = bcd[4*dptr_ff +: 4];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      bitcnt_in        = bitcnt_ff;
      dptr_in          = dptr_ff;
      neg_in           = neg_ff;
      ctrl             = '0;
      req_ready        = 1'b0;
      out_load         = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               neg_in    = req_value[INPUT_BITS-1];
               bitcnt_in = CW'(INPUT_BITS - 1);
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl.shift = 1'b1;
            if (bitcnt_ff == '0) begin
               state_in = ST_FIND;
            end else begin
               bitcnt_in = bitcnt_ff - 1'b1;
            end
         end
         ST_FIND: begin
            dptr_in  = top;
            state_in = neg_ff ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (out_free) begin
               out_load         = 1'b1;
               rsp_character_in = ASCII_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               out_load         = 1'b1;
               rsp_character_in = ASCII_ZERO + {4'd0, digit};
               rsp_last_in      = (dptr_ff == '0);
               if (dptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  dptr_in = dptr_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bitcnt_ff        <= bitcnt_in;
      dptr_ff          <= dptr_in;
      neg_ff           <= neg_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // accepted request starts a full-length conversion
   a_conv_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (state_ff == ST_CONV && bitcnt_ff == CW'(INPUT_BITS - 1)))
      else $error("conversion did not start with full bit count");

   // leading digit is never zero unless it is the only digit
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |=> (dptr_ff == '0 || digit != 4'd0))
      else $error("leading zero digit selected");

   // final digit closes the run and frees the sequencer
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGITS && out_free && dptr_ff == '0) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("run did not end with last flag");

   // a minus sign never ends a run, digits stay in range
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_character_ff == ASCII_MINUS && !rsp_last_ff) ||
          (rsp_character_ff >= ASCII_ZERO && rsp_character_ff <= ASCII_ZERO + 8'd9)))
      else $error("bad response character");

endmodule
